@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked while out of reset.
`define DFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DFE_ASSERT(lbl, clk, rstn, prop, msg)
`define DFE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ sv/dfe_pkg.sv @@
package dfe_pkg;

    // Command codes
    localparam logic [2:0] CMD_ERASE_PROG = 3'd0;
    localparam logic [2:0] CMD_ERASE_SETT = 3'd1;
    localparam logic [2:0] CMD_WRITE_PROG = 3'd2;
    localparam logic [2:0] CMD_WRITE_SETT = 3'd3;
    localparam logic [2:0] CMD_INVOKE     = 3'd4;
    localparam logic [2:0] CMD_USER       = 3'd5;

    // Request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CNT  = 2'd1;
    localparam logic [1:0] ERR_NO_FRAME = 2'd2;
    localparam logic [1:0] ERR_OPEN     = 2'd3;

    localparam logic [7:0] HDR_A          = 8'h07;
    localparam logic [7:0] HDR_B          = 8'h0E;
    localparam logic [7:0] WRITE_MAX_CNT  = 8'd26;
    localparam logic [7:0] USER_MAX_CNT   = 8'd29;
    localparam logic [7:0] USER_CODE_RST  = 8'd90;
    localparam logic [7:0] WRITE_LEN_ADD  = 8'd4;
    localparam logic [7:0] USER_LEN_ADD   = 8'd1;
    localparam logic [7:0] INVOKE_LEN     = 8'd4;
    localparam logic [7:0] CH_WP_A        = 8'h35;
    localparam logic [7:0] CH_WP_B        = 8'h37;
    localparam logic [7:0] CH_WS_A        = 8'h34;
    localparam logic [7:0] CH_WS_B        = 8'h35;
    localparam logic [7:0] CH_INV         = 8'h35;

    // Bytes per job
    localparam logic [3:0] N_ERR    = 4'd1;
    localparam logic [3:0] N_ERASE  = 4'd6;
    localparam logic [3:0] N_USER   = 4'd5;
    localparam logic [3:0] N_WRITE  = 4'd11;
    localparam logic [3:0] N_INVOKE = 4'd12;
    localparam logic [3:0] N_DATA   = 4'd2;
    localparam logic [3:0] N_DATA_C = 4'd3;

    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        JOB_ERR,
        JOB_ERASE,
        JOB_HDR,
        JOB_DATA
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  cmd;
        logic [1:0]  err;
        logic [7:0]  len;
        logic [23:0] addr;
        logic [7:0]  dat;
        logic [3:0]  nbytes;
        logic        ends;    // final byte carries frame_last
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib <= 4'd9) ? {4'h3, nib} : ({4'h0, nib} + 8'h37);
    endfunction

    function automatic logic [7:0] erase_byte(input logic sett, input logic [3:0] idx);
        case (idx)
            4'd0:    erase_byte = HDR_A;
            4'd1:    erase_byte = HDR_B;
            4'd2:    erase_byte = 8'h01;
            4'd3:    erase_byte = 8'h34;
            4'd4:    erase_byte = sett ? 8'h31 : 8'h33;
            default: erase_byte = sett ? 8'h9B : 8'h99;
        endcase
    endfunction

endpackage

@@ sv/dfe_front.sv @@
module dfe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic                req_type,
    input  logic [2:0]          command,
    input  logic [23:0]         address,
    input  logic [7:0]          byte_count,
    input  logic [7:0]          data_byte,
    output dfe_pkg::job_t       job
);
    import dfe_pkg::*;

    logic       frame_open_reg, frame_open_next;
    logic [4:0] bytes_left_reg, bytes_left_next;
    logic [4:0] left_dec;

    assign left_dec = bytes_left_reg - 5'd1;

    always_comb begin
        job             = '0;
        job.kind        = JOB_ERR;
        job.cmd         = command;
        job.addr        = address;
        job.dat         = data_byte;
        job.err         = ERR_BAD_CNT;
        job.nbytes      = N_ERR;
        job.ends        = 1'b1;
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;

        if (req_type == REQ_DATA) begin
            if (!frame_open_reg) begin
                job.err = ERR_NO_FRAME;
            end else begin
                job.kind        = JOB_DATA;
                job.err         = ERR_NONE;
                job.ends        = (left_dec == 5'd0);
                job.nbytes      = (left_dec == 5'd0) ? N_DATA_C : N_DATA;
                bytes_left_next = left_dec;
                if (left_dec == 5'd0) begin
                    frame_open_next = 1'b0;
                end
            end
        end else if (frame_open_reg) begin
            job.err = ERR_OPEN;
        end else begin
            case (command)
                CMD_ERASE_PROG, CMD_ERASE_SETT: begin
                    job.kind   = JOB_ERASE;
                    job.err    = ERR_NONE;
                    job.nbytes = N_ERASE;
                end
                CMD_WRITE_PROG, CMD_WRITE_SETT: begin
                    if (byte_count inside {[8'd1:WRITE_MAX_CNT]}) begin
                        job.kind        = JOB_HDR;
                        job.err         = ERR_NONE;
                        job.len         = byte_count + WRITE_LEN_ADD;
                        job.nbytes      = N_WRITE;
                        job.ends        = 1'b0;
                        frame_open_next = 1'b1;
                        bytes_left_next = byte_count[4:0];
                    end
                end
                CMD_INVOKE: begin
                    job.kind   = JOB_HDR;
                    job.err    = ERR_NONE;
                    job.len    = INVOKE_LEN;
                    job.nbytes = N_INVOKE;
                end
                CMD_USER: begin
                    if (byte_count inside {[8'd1:USER_MAX_CNT]}) begin
                        job.kind        = JOB_HDR;
                        job.err         = ERR_NONE;
                        job.len         = byte_count + USER_LEN_ADD;
                        job.nbytes      = N_USER;
                        job.ends        = 1'b0;
                        frame_open_next = 1'b1;
                        bytes_left_next = byte_count[4:0];
                    end
                end
                default: begin
                    job.err = ERR_BAD_CNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
        end else if (take) begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

@@ sv/dfe_queue.sv @@
module dfe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dfe_pkg::job_t   push_job,
    output logic            full,
    output logic            head_valid,
    output dfe_pkg::job_t   head_job,
    input  logic            pop
);
    import dfe_pkg::*;

    job_t       slot_reg [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'(Q_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ sv/dfe_back.sv @@
module dfe_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    input  dfe_pkg::job_t   job,
    output logic            job_pop,
    input  logic [7:0]      user_cmd_code,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_frame_last,
    output logic [1:0]      m_error
);
    import dfe_pkg::*;

    logic [3:0] step_reg, step_next;
    logic [7:0] sum_reg, sum_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [1:0] err_reg;

    logic       fire, final_step, counts;
    logic [7:0] cur_byte, chk, addr_ch;
    logic       is_user;

    assign fire       = job_valid && (!m_valid_reg || m_ready);
    assign final_step = (step_reg == job.nbytes - 4'd1);
    assign job_pop    = fire && final_step;
    assign chk        = 8'd0 - sum_reg;
    assign is_user    = (job.cmd == CMD_USER);

    always_comb begin
        case (step_reg)
            4'd5:    addr_ch = hex_char(job.addr[3:0]);
            4'd6:    addr_ch = hex_char(job.addr[7:4]);
            4'd7:    addr_ch = hex_char(job.addr[11:8]);
            4'd8:    addr_ch = hex_char(job.addr[15:12]);
            4'd9:    addr_ch = hex_char(job.addr[19:16]);
            default: addr_ch = hex_char(job.addr[23:20]);
        endcase
    end

    always_comb begin
        cur_byte = 8'd0;
        counts   = 1'b0;
        case (job.kind)
            JOB_ERR: begin
                cur_byte = 8'd0;
            end
            JOB_ERASE: begin
                cur_byte = erase_byte(job.cmd == CMD_ERASE_SETT, step_reg);
            end
            JOB_DATA: begin
                case (step_reg)
                    4'd0: begin
                        cur_byte = hex_char(job.dat[3:0]);
                        counts   = 1'b1;
                    end
                    4'd1: begin
                        cur_byte = hex_char(job.dat[7:4]);
                        counts   = 1'b1;
                    end
                    default: cur_byte = chk;
                endcase
            end
            default: begin
                counts = (step_reg inside {[4'd3:4'd10]});
                case (step_reg)
                    4'd0: cur_byte = HDR_A;
                    4'd1: cur_byte = HDR_B;
                    4'd2: cur_byte = job.len;
                    4'd3: begin
                        if (is_user) begin
                            cur_byte = hex_char(user_cmd_code[3:0]);
                        end else if (job.cmd == CMD_WRITE_PROG) begin
                            cur_byte = CH_WP_A;
                        end else if (job.cmd == CMD_WRITE_SETT) begin
                            cur_byte = CH_WS_A;
                        end else begin
                            cur_byte = CH_INV;
                        end
                    end
                    4'd4: begin
                        if (is_user) begin
                            cur_byte = hex_char(user_cmd_code[7:4]);
                        end else if (job.cmd == CMD_WRITE_PROG) begin
                            cur_byte = CH_WP_B;
                        end else if (job.cmd == CMD_WRITE_SETT) begin
                            cur_byte = CH_WS_B;
                        end else begin
                            cur_byte = CH_INV;
                        end
                    end
                    4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: cur_byte = addr_ch;
                    default: cur_byte = chk;
                endcase
            end
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fire) begin
            m_valid_next = 1'b1;
            step_next    = final_step ? 4'd0 : step_reg + 4'd1;
            // restart the checksum on each new header
            if (job.kind == JOB_HDR && step_reg == 4'd0) begin
                sum_next = 8'd0;
            end else if (counts) begin
                sum_next = sum_reg + cur_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg <= cur_byte;
            last_reg <= final_step && job.ends;
            err_reg  <= job.err;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_frame_last = last_reg;
    assign m_error      = err_reg;

endmodule

@@ sv/download_frame_encoder.sv @@
// Channel  | Direction | Beat carries
// ---------+-----------+------------------------------------------------------
// s_       | in        | req_type, command, address, byte_count, data_byte
// m_       | out       | out_byte, frame_last, error
// cfg_     | in        | user_cmd_code
//
// One frame byte leaves per cycle from the back sequencer's output register
// while a job is queued and m_ready is high. An item causes 1 frame byte for
// an error, 2 or 3 for a payload byte, and 5, 6, 11 or 12 for a start.
// A two-entry job queue sits between the classifier and the sequencer; s_ready
// drops only while it is full. cfg_ready is always high.
// Reset (aresetn low, synchronous) closes any frame, empties the queue and
// restores user_cmd_code to 'Z'.
`include "assert_macros.svh"

module download_frame_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [2:0]  s_command,
    input  logic [23:0] s_address,
    input  logic [7:0]  s_byte_count,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_last,
    output logic [1:0]  m_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_user_cmd_code
);
    import dfe_pkg::*;

    logic       take, q_full, q_valid, q_pop;
    job_t       front_job, head_job;
    logic [7:0] user_code_reg;

    assign s_ready   = !q_full;
    assign take      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            user_code_reg <= USER_CODE_RST;
        end else if (cfg_valid) begin
            user_code_reg <= cfg_user_cmd_code;
        end
    end

    dfe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .req_type   (s_req_type),
        .command    (s_command),
        .address    (s_address),
        .byte_count (s_byte_count),
        .data_byte  (s_data_byte),
        .job        (front_job)
    );

    dfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (take),
        .push_job   (front_job),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (head_job),
        .pop        (q_pop)
    );

    dfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_valid),
        .job           (head_job),
        .job_pop       (q_pop),
        .user_cmd_code (user_code_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_last  (m_frame_last),
        .m_error       (m_error)
    );

    `DFE_ASSERT(a_err_is_last, aclk, aresetn, (m_valid && m_error != ERR_NONE) |-> m_frame_last, "error beat without frame_last")
    `DFE_ASSERT(a_err_zero, aclk, aresetn, (m_valid && m_error != ERR_NONE) |-> (m_out_byte == 8'd0), "error beat with non-zero byte")
    `DFE_ASSERT(a_pop_needs_job, aclk, aresetn, q_pop |-> q_valid, "job popped from empty queue")
    `DFE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

@@ tb/sv/download_frame_encoder_tb.sv @@
module download_frame_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfe_pkg::*;

    // command values outside the defined set
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    typedef struct {
        logic        req;
        logic [2:0]  cmd;
        logic [23:0] addr;
        logic [7:0]  cnt;
        logic [7:0]  dat;
    } link_req_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic [1:0] err;
    } frame_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_START;
    logic [2:0]  s_command = CMD_ERASE_PROG;
    logic [23:0] s_address = '0;
    logic [7:0]  s_byte_count = '0;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_frame_last;
    logic [1:0]  m_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_user_cmd_code = '0;

    link_req_t   pending_reqs[$];
    frame_beat_t frame_beats_due[$];

    // encoder state as predicted from accepted beats
    logic        frame_open_m = 1'b0;
    logic [4:0]  bytes_left_m = '0;
    logic [7:0]  running_sum_m = '0;
    logic [7:0]  user_code_m = USER_CODE_RST;

    int          items_queued = 0;
    int          items_taken = 0;
    int          mismatches = 0;
    logic        s_accepted = 1'b0;
    bit          calm_tail = 1'b0;
    int          s_gap_left = 0;
    int          m_stall_left = 0;

    download_frame_encoder uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_command         (s_command),
        .s_address         (s_address),
        .s_byte_count      (s_byte_count),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_frame_last      (m_frame_last),
        .m_error           (m_error),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_user_cmd_code (cfg_user_cmd_code)
    );

    always #4 aclk = ~aclk;

    task automatic report(input string msg);
        mismatches++;
        $display("%0t ns: check failed: %s", $time, msg);
    endtask

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    task automatic emit(input logic [7:0] v, input logic last, input logic [1:0] err);
        frame_beat_t b;
        b.value = v;
        b.last  = last;
        b.err   = err;
        frame_beats_due.push_back(b);
    endtask

    task automatic emit_summed(input logic [7:0] v);
        running_sum_m = running_sum_m + v;
        emit(v, 1'b0, ERR_NONE);
    endtask

    task automatic emit_hex(input logic [7:0] v);
        emit_summed(ascii_hex(v[3:0]));
        emit_summed(ascii_hex(v[7:4]));
    endtask

    task automatic emit_checksum();
        emit(~running_sum_m + 8'd1, 1'b1, ERR_NONE);
    endtask

    // Work out the frame bytes that one accepted beat causes.
    task automatic encode_item(input link_req_t r);
        logic sett;
        int   i;
        if (r.req == REQ_DATA) begin
            if (!frame_open_m) begin
                emit(8'h00, 1'b1, ERR_NO_FRAME);
            end else begin
                emit_hex(r.dat);
                bytes_left_m = bytes_left_m - 5'd1;
                if (bytes_left_m == 5'd0) begin
                    emit_checksum();
                    frame_open_m = 1'b0;
                end
            end
        end else if (frame_open_m) begin
            emit(8'h00, 1'b1, ERR_OPEN);
        end else begin
            case (r.cmd)
                CMD_ERASE_PROG, CMD_ERASE_SETT: begin
                    sett = (r.cmd == CMD_ERASE_SETT);
                    emit(HDR_A, 1'b0, ERR_NONE);
                    emit(HDR_B, 1'b0, ERR_NONE);
                    emit(8'h01, 1'b0, ERR_NONE);
                    emit(8'h34, 1'b0, ERR_NONE);
                    emit(sett ? 8'h31 : 8'h33, 1'b0, ERR_NONE);
                    emit(sett ? 8'h9B : 8'h99, 1'b1, ERR_NONE);
                end
                CMD_WRITE_PROG, CMD_WRITE_SETT, CMD_INVOKE: begin
                    if (r.cmd != CMD_INVOKE && (r.cnt == 8'd0 || r.cnt > WRITE_MAX_CNT)) begin
                        emit(8'h00, 1'b1, ERR_BAD_CNT);
                    end else begin
                        running_sum_m = '0;
                        emit(HDR_A, 1'b0, ERR_NONE);
                        emit(HDR_B, 1'b0, ERR_NONE);
                        emit((r.cmd == CMD_INVOKE) ? INVOKE_LEN : r.cnt + WRITE_LEN_ADD,
                             1'b0, ERR_NONE);
                        case (r.cmd)
                            CMD_WRITE_PROG: begin
                                emit_summed(CH_WP_A);
                                emit_summed(CH_WP_B);
                            end
                            CMD_WRITE_SETT: begin
                                emit_summed(CH_WS_A);
                                emit_summed(CH_WS_B);
                            end
                            default: begin
                                emit_summed(CH_INV);
                                emit_summed(CH_INV);
                            end
                        endcase
                        for (i = 0; i < 6; i++) begin
                            emit_summed(ascii_hex(r.addr[4*i +: 4]));
                        end
                        if (r.cmd == CMD_INVOKE) begin
                            emit_checksum();
                        end else begin
                            frame_open_m = 1'b1;
                            bytes_left_m = r.cnt[4:0];
                        end
                    end
                end
                CMD_USER: begin
                    if (r.cnt == 8'd0 || r.cnt > USER_MAX_CNT) begin
                        emit(8'h00, 1'b1, ERR_BAD_CNT);
                    end else begin
                        running_sum_m = '0;
                        emit(HDR_A, 1'b0, ERR_NONE);
                        emit(HDR_B, 1'b0, ERR_NONE);
                        emit(r.cnt + USER_LEN_ADD, 1'b0, ERR_NONE);
                        emit_hex(user_code_m);
                        frame_open_m = 1'b1;
                        bytes_left_m = r.cnt[4:0];
                    end
                end
                default: begin
                    emit(8'h00, 1'b1, ERR_BAD_CNT);
                end
            endcase
        end
    endtask

    // Input side: present queued beats, with bursts of idle cycles.
    always @(negedge aclk) begin
        link_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_accepted) begin
            if (s_gap_left != 0) begin
                s_gap_left--;
                s_valid <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                s_gap_left = $urandom_range(0, 5);
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                r = pending_reqs.pop_front();
                s_req_type   <= r.req;
                s_command    <= r.cmd;
                s_address    <= r.addr;
                s_byte_count <= r.cnt;
                s_data_byte  <= r.dat;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output side: stall in bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_stall_left != 0) begin
            m_stall_left--;
            m_ready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            m_stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watch
        link_req_t   seen;
        frame_beat_t want;
        if (!aresetn) begin
            s_accepted <= 1'b0;
        end else begin
            s_accepted <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                user_code_m = cfg_user_cmd_code;
            end
            if (s_valid && s_ready) begin
                seen.req  = s_req_type;
                seen.cmd  = s_command;
                seen.addr = s_address;
                seen.cnt  = s_byte_count;
                seen.dat  = s_data_byte;
                encode_item(seen);
                items_taken++;
            end
            if (m_valid && m_ready) begin
                if (frame_beats_due.size() == 0) begin
                    report($sformatf("unexpected beat out_byte %h last %b error %0d",
                                     m_out_byte, m_frame_last, m_error));
                end else begin
                    want = frame_beats_due.pop_front();
                    if (m_out_byte !== want.value) begin
                        report($sformatf("out_byte %h, want %h", m_out_byte, want.value));
                    end
                    if (m_frame_last !== want.last) begin
                        report($sformatf("frame_last %b, want %b", m_frame_last, want.last));
                    end
                    if (m_error !== want.err) begin
                        report($sformatf("error %0d, want %0d", m_error, want.err));
                    end
                end
            end
        end
    end

    task automatic queue_req(input logic req, input logic [2:0] cmd, input logic [23:0] addr,
                             input logic [7:0] cnt, input logic [7:0] dat);
        link_req_t r;
        r.req  = req;
        r.cmd  = cmd;
        r.addr = addr;
        r.cnt  = cnt;
        r.dat  = dat;
        pending_reqs.push_back(r);
        items_queued++;
    endtask

    task automatic queue_start(input logic [2:0] cmd, input logic [7:0] cnt);
        queue_req(REQ_START, cmd, 24'($urandom), cnt, 8'($urandom));
    endtask

    task automatic queue_data(input logic [7:0] dat);
        queue_req(REQ_DATA, 3'($urandom), 24'($urandom), 8'($urandom), dat);
    endtask

    // One command sequence with random payload; now and then a stray start mid-frame.
    task automatic queue_frame(input logic [2:0] cmd, input logic [7:0] cnt);
        int k;
        queue_start(cmd, cnt);
        if (cmd == CMD_WRITE_PROG || cmd == CMD_WRITE_SETT || cmd == CMD_USER) begin
            for (k = 0; k < cnt; k++) begin
                if ($urandom_range(0, 24) == 0) begin
                    queue_start(3'($urandom), 8'($urandom));
                end
                queue_data(8'($urandom));
            end
        end
    endtask

    task automatic queue_traffic(input int n);
        int         stop;
        logic [2:0] cmd;
        logic [7:0] top;
        int         pick;
        stop = items_queued + n;
        while (items_queued < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                cmd = 3'($urandom_range(0, 5));
                top = (cmd == CMD_USER) ? USER_MAX_CNT : WRITE_MAX_CNT;
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    queue_frame(cmd, top);
                end else if (pick < 5) begin
                    queue_frame(cmd, 8'($urandom_range(1, top)));
                end else begin
                    queue_frame(cmd, 8'($urandom_range(1, 6)));
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: queue_data(8'($urandom));
                    1: queue_start($urandom_range(0, 1) ? CMD_WRITE_PROG : CMD_WRITE_SETT,
                                   $urandom_range(0, 3) == 0 ? 8'd0 :
                                   8'($urandom_range(WRITE_MAX_CNT + 1, 255)));
                    2: queue_start(CMD_USER, $urandom_range(0, 3) == 0 ? 8'd0 :
                                   8'($urandom_range(USER_MAX_CNT + 1, 255)));
                    3: queue_start($urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7,
                                   8'($urandom));
                    default: queue_start(CMD_INVOKE, 8'($urandom));
                endcase
            end
        end
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || frame_beats_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_user_code(input logic [7:0] v);
        @(negedge aclk);
        cfg_valid         <= 1'b1;
        cfg_user_cmd_code <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int         ph;
        logic [7:0] code;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, user code still at its reset value
        queue_req(REQ_START, CMD_ERASE_PROG, 24'hFFFFFF, 8'hFF, 8'hFF);
        queue_req(REQ_START, CMD_ERASE_SETT, 24'h000000, 8'h00, 8'h00);
        queue_req(REQ_START, CMD_INVOKE, 24'h000000, 8'h00, 8'h00);
        queue_req(REQ_START, CMD_INVOKE, 24'hFFFFFF, 8'hFF, 8'hFF);
        queue_req(REQ_START, CMD_INVOKE, 24'h9A5F30, 8'h07, 8'h00);
        queue_start(CMD_WRITE_PROG, 8'd1);
        queue_data(8'h00);
        queue_start(CMD_WRITE_SETT, 8'd2);
        queue_data(8'hFF);
        queue_data(8'h9A);
        queue_start(CMD_USER, 8'd1);
        queue_data(8'h5C);
        queue_data(8'h11);
        queue_start(CMD_WRITE_PROG, 8'd0);
        queue_start(CMD_WRITE_SETT, WRITE_MAX_CNT + 8'd1);
        queue_start(CMD_USER, 8'd0);
        queue_start(CMD_USER, USER_MAX_CNT + 8'd1);
        queue_start(CMD_WRITE_PROG, 8'hFF);
        queue_start(CMD_RSVD_6, 8'd1);
        queue_start(CMD_RSVD_7, 8'd1);
        // start arriving mid-frame must leave the open frame intact
        queue_start(CMD_WRITE_PROG, 8'd2);
        queue_data(8'h3C);
        queue_start(CMD_ERASE_PROG, 8'd0);
        queue_data(8'hC3);
        wait_idle();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       code = 8'h00;
                1:       code = 8'hFF;
                default: code = 8'($urandom_range(1, 254));
            endcase
            write_user_code(code);
            if (ph == 3) begin
                calm_tail = 1'b1;
            end
            queue_traffic(68);
            wait_idle();
        end

        repeat (16) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/dfe_pkg.sv
sv/dfe_front.sv
sv/dfe_queue.sv
sv/dfe_back.sv
sv/download_frame_encoder.sv
tb/sv/download_frame_encoder_tb.sv
